>>> rtl/wtsp_pkg.sv
// ----------------------------------------------------------------------------
// wtsp_pkg
// Types and constants shared by the world-to-screen projection pipeline.
// ----------------------------------------------------------------------------
package wtsp_pkg;

    localparam int MATRIX_FRAC_BITS = 8;
    localparam int COORD_FRAC_BITS  = 16;

    // Clip coordinate, clip plus w, scaled numerator and its magnitude
    localparam int CW  = 50;
    localparam int AW  = CW + 1;
    localparam int BW  = 17;
    localparam int ABW = AW + BW;
    localparam int NW  = ABW - 1;
    // Quotient bits kept; a larger quotient saturates its own output
    localparam int QB  = 26;
    localparam int TW  = QB + 2;
    localparam int SW  = TW + 1;

    localparam logic signed [BW-1:0] DEPTH_SCALE = BW'(1 << 15);
    localparam logic signed [SW-1:0] XY_MAX = SW'(8388607);
    localparam logic signed [SW-1:0] XY_MIN = -SW'(8388608);
    localparam logic signed [TW-1:0] DEPTH_MAX = TW'(65535);

    localparam logic [63:0] ROW0_RESET = 64'(1) << MATRIX_FRAC_BITS;
    localparam logic [63:0] ROW1_RESET = ROW0_RESET << 16;
    localparam logic [63:0] ROW2_RESET = ROW0_RESET << 32;
    localparam logic [63:0] ROW3_RESET = ROW0_RESET << 48;

    typedef enum logic [3:0] {
        REG_ROW0      = 4'd0,
        REG_ROW1      = 4'd1,
        REG_ROW2      = 4'd2,
        REG_ROW3      = 4'd3,
        REG_VP_LEFT   = 4'd4,
        REG_VP_TOP    = 4'd5,
        REG_VP_WIDTH  = 4'd6,
        REG_VP_HEIGHT = 4'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic signed [31:0] world_z;
    } in_t;

    typedef struct packed {
        logic signed [23:0] screen_x;
        logic signed [23:0] screen_y;
        logic        [15:0] screen_depth;
        logic               w_zero;
        logic               saturated;
    } out_t;

endpackage

>>> rtl/world_to_screen_projection.sv
// ----------------------------------------------------------------------------
// world_to_screen_projection
// Matrix transform, perspective divide and viewport mapping of world points.
// ----------------------------------------------------------------------------
// Takes one point per cycle while the output is not stalled and returns one
// result per point, in order.
// Stages: 16x32 products, row sums, add w, scale by viewport size, then a
// restoring divider by |w| that retires one quotient bit per stage for all
// three lanes, a sign fixup stage and a saturating output register. Each stage
// holds its beat only while the stage after it is full and blocked, so bubbles
// close up. Matrix and viewport registers may be written only when the
// pipeline is empty; cfg_ready is always high.
module world_to_screen_projection (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  wtsp_pkg::in_t       s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output wtsp_pkg::out_t      m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [3:0]          cfg_index,
    input  logic [63:0]         cfg_data
);
    import wtsp_pkg::*;

    localparam int ST_PROD = 0;
    localparam int ST_SUM  = 1;
    localparam int ST_ADDW = 2;
    localparam int ST_MUL  = 3;
    localparam int ST_DIV  = 4;
    localparam int ST_FIX  = ST_DIV + QB + 1;
    localparam int ST_OUT  = ST_FIX + 1;
    localparam int NS      = ST_OUT + 1;

    // Configuration
    logic [63:0]        row_reg [4];
    logic signed [15:0] vp_left_reg, vp_top_reg, vp_width_reg, vp_height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg[0]    <= ROW0_RESET;
            row_reg[1]    <= ROW1_RESET;
            row_reg[2]    <= ROW2_RESET;
            row_reg[3]    <= ROW3_RESET;
            vp_left_reg   <= 16'sd0;
            vp_top_reg    <= 16'sd1;
            vp_width_reg  <= 16'sd1;
            vp_height_reg <= -16'sd1;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_ROW0:      row_reg[0]    <= cfg_data;
                REG_ROW1:      row_reg[1]    <= cfg_data;
                REG_ROW2:      row_reg[2]    <= cfg_data;
                REG_ROW3:      row_reg[3]    <= cfg_data;
                REG_VP_LEFT:   vp_left_reg   <= cfg_data[15:0];
                REG_VP_TOP:    vp_top_reg    <= cfg_data[15:0];
                REG_VP_WIDTH:  vp_width_reg  <= cfg_data[15:0];
                REG_VP_HEIGHT: vp_height_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Flow control: a stage loads when it is empty or its beat moves on
    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;

    always_comb begin
        en[NS-1] = !v_reg[NS-1] || m_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign s_ready = en[0];
    assign m_valid = v_reg[NS-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= s_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // Stage: products
    logic signed [47:0] prod_reg [4][4];
    logic signed [47:0] prod_next [4][4];
    logic signed [31:0] pin [3];

    always_comb begin
        pin[0] = s_data.world_x;
        pin[1] = s_data.world_y;
        pin[2] = s_data.world_z;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 3; j++) begin
                prod_next[i][j] = $signed(row_reg[i][16*j +: 16]) * pin[j];
            end
            prod_next[i][3] = $signed({{(32-COORD_FRAC_BITS){row_reg[i][63]}},
                                       row_reg[i][63:48], {COORD_FRAC_BITS{1'b0}}});
        end
    end

    // Stage: row sums
    logic signed [CW-1:0] c_reg [4];
    logic signed [CW-1:0] c_next [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            c_next[i] = prod_reg[i][0] + prod_reg[i][1] + prod_reg[i][2] + prod_reg[i][3];
        end
    end

    // Stage: add w
    logic signed [AW-1:0] a_reg [3];
    logic signed [AW-1:0] a_next [3];
    logic signed [CW-1:0] w_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            a_next[k] = c_reg[k] + c_reg[3];
        end
    end

    // Stage: scale by viewport size
    logic signed [ABW-1:0] ab_reg [3];
    logic signed [ABW-1:0] ab_next [3];
    logic signed [BW-1:0]  scl [3];
    logic [CW-1:0]         wmag_reg;
    logic                  wneg_reg;
    logic                  wz_reg;

    always_comb begin
        scl[0] = BW'(vp_width_reg);
        scl[1] = BW'(vp_height_reg);
        scl[2] = DEPTH_SCALE;
        for (int k = 0; k < 3; k++) begin
            ab_next[k] = a_reg[k] * scl[k];
        end
    end

    // Divider pipe: index 0 takes magnitudes, index s+1 retires one bit
    logic [NW-1:0]   dr_reg  [QB+1][3];
    logic [QB-1:0]   dq_reg  [QB+1][3];
    logic            dneg_reg[QB+1][3];
    logic            dovf_reg[QB+1][3];
    logic [CW-1:0]   dd_reg  [QB+1];
    logic            dwz_reg [QB+1];

    logic [NW-1:0]   dr_next [QB+1][3];
    logic [QB-1:0]   dq_next [QB+1][3];
    logic            dovf0_next [3];
    logic [NW+QB-1:0] dsh;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            dr_next[0][k]  = ab_reg[k][ABW-1] ? NW'(-ab_reg[k]) : NW'(ab_reg[k]);
            dq_next[0][k]  = '0;
            dovf0_next[k]  = ({QB'(0), dr_next[0][k]} >= {wmag_reg, {(NW+QB-CW){1'b0}}}
                              >> (NW - CW));
        end
        dsh = '0;
        for (int s = 0; s < QB; s++) begin
            dsh = (NW+QB)'(dd_reg[s]) << (QB - 1 - s);
            for (int k = 0; k < 3; k++) begin
                dr_next[s+1][k] = dr_reg[s][k];
                dq_next[s+1][k] = dq_reg[s][k];
                if ({QB'(0), dr_reg[s][k]} >= dsh) begin
                    dr_next[s+1][k] = dr_reg[s][k] - NW'(dsh);
                    dq_next[s+1][k][QB-1-s] = 1'b1;
                end
            end
        end
    end

    // Stage: sign fixup to floor quotient
    logic signed [TW-1:0] t_reg [3];
    logic signed [TW-1:0] t_next [3];
    logic                 tneg_reg [3];
    logic                 tovf_reg [3];
    logic                 twz_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (dneg_reg[QB][k]) begin
                t_next[k] = -$signed({2'b00, dq_reg[QB][k]})
                            - TW'(dr_reg[QB][k] != '0);
            end else begin
                t_next[k] = $signed({2'b00, dq_reg[QB][k]});
            end
        end
    end

    // Stage: viewport offset and saturation
    out_t                 out_reg;
    out_t                 out_next;
    logic signed [SW-1:0] sxy [2];
    logic signed [15:0]   org [2];
    logic [1:0]           xy_sat;
    logic signed [23:0]   xy_val [2];
    logic                 d_sat;
    logic [15:0]          d_val;

    always_comb begin
        org[0] = vp_left_reg;
        org[1] = vp_top_reg;
        for (int k = 0; k < 2; k++) begin
            sxy[k] = SW'(t_reg[k] >>> 1) + SW'(org[k]);
            if (tovf_reg[k]) begin
                xy_sat[k] = 1'b1;
                xy_val[k] = tneg_reg[k] ? 24'(XY_MIN) : 24'(XY_MAX);
            end else if (sxy[k] > XY_MAX) begin
                xy_sat[k] = 1'b1;
                xy_val[k] = 24'(XY_MAX);
            end else if (sxy[k] < XY_MIN) begin
                xy_sat[k] = 1'b1;
                xy_val[k] = 24'(XY_MIN);
            end else begin
                xy_sat[k] = 1'b0;
                xy_val[k] = 24'(sxy[k]);
            end
        end
        if (tovf_reg[2]) begin
            d_sat = 1'b1;
            d_val = tneg_reg[2] ? 16'd0 : 16'hFFFF;
        end else if (t_reg[2] > DEPTH_MAX) begin
            d_sat = 1'b1;
            d_val = 16'hFFFF;
        end else if (t_reg[2] < 0) begin
            d_sat = 1'b1;
            d_val = 16'd0;
        end else begin
            d_sat = 1'b0;
            d_val = 16'(t_reg[2]);
        end
        if (twz_reg) begin
            out_next = '0;
            out_next.w_zero = 1'b1;
        end else begin
            out_next.screen_x     = xy_val[0];
            out_next.screen_y     = xy_val[1];
            out_next.screen_depth = d_val;
            out_next.w_zero       = 1'b0;
            out_next.saturated    = xy_sat[0] || xy_sat[1] || d_sat;
        end
    end

    assign m_data = out_reg;

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (en[ST_PROD]) prod_reg <= prod_next;
        if (en[ST_SUM])  c_reg <= c_next;
        if (en[ST_ADDW]) begin
            a_reg <= a_next;
            w_reg <= c_reg[3];
        end
        if (en[ST_MUL]) begin
            ab_reg   <= ab_next;
            wmag_reg <= w_reg[CW-1] ? CW'(-w_reg) : CW'(w_reg);
            wneg_reg <= w_reg[CW-1];
            wz_reg   <= (w_reg == '0);
        end
        if (en[ST_DIV]) begin
            for (int k = 0; k < 3; k++) begin
                dr_reg[0][k]   <= dr_next[0][k];
                dq_reg[0][k]   <= dq_next[0][k];
                dneg_reg[0][k] <= ab_reg[k][ABW-1] ^ wneg_reg;
                dovf_reg[0][k] <= dovf0_next[k];
            end
            dd_reg[0]  <= wmag_reg;
            dwz_reg[0] <= wz_reg;
        end
        for (int s = 0; s < QB; s++) begin
            if (en[ST_DIV+s+1]) begin
                for (int k = 0; k < 3; k++) begin
                    dr_reg[s+1][k]   <= dr_next[s+1][k];
                    dq_reg[s+1][k]   <= dq_next[s+1][k];
                    dneg_reg[s+1][k] <= dneg_reg[s][k];
                    dovf_reg[s+1][k] <= dovf_reg[s][k];
                end
                dd_reg[s+1]  <= dd_reg[s];
                dwz_reg[s+1] <= dwz_reg[s];
            end
        end
        if (en[ST_FIX]) begin
            for (int k = 0; k < 3; k++) begin
                t_reg[k]    <= t_next[k];
                tneg_reg[k] <= dneg_reg[QB][k];
                tovf_reg[k] <= dovf_reg[QB][k];
            end
            twz_reg <= dwz_reg[QB];
        end
        if (en[ST_OUT]) out_reg <= out_next;
    end

endmodule

>>> tb/world_to_screen_projection_test.sv
// ----------------------------------------------------------------------------
// world_to_screen_projection_test
// Checks the projection pipeline against its own bit-exact predictor.
// ----------------------------------------------------------------------------
// A directed table of points and register writes, then random phases under
// fresh matrix and viewport settings. Both sides of the stream idle at random;
// one phase holds the result side off for a long stretch. Every result is
// compared field by field with the oldest expected projection.
module world_to_screen_projection_test;
    import wtsp_pkg::*;

    localparam int LATENCY      = 40;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 400;
    localparam int PHASES       = 10;
    localparam logic [3:0] REG_NONE = 4'd12;   // beyond the register list

    typedef struct {
        bit          is_write;
        logic [3:0]  idx;
        logic [63:0] wdata;
        in_t         pt;
        bit          known;
        out_t        res;
    } step_t;

    logic  aclk;
    logic  aresetn;
    logic  s_valid;
    logic  s_ready;
    in_t   s_data;
    logic  m_valid;
    logic  m_ready;
    out_t  m_data;
    logic  cfg_valid;
    logic  cfg_ready;
    logic  [3:0] cfg_index;
    logic  [63:0] cfg_data;

    // predictor copy of the registers
    logic [63:0]        mat [4];
    logic signed [15:0] vp_left, vp_top, vp_width, vp_height;

    out_t  pending_q [$];
    step_t table_q [$];
    int    mismatches, n_items, n_results, n_wzero, n_sat, n_writes;
    longint cycles;
    bit    idle_on, long_hold_req, hold_active;

    world_to_screen_projection DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic longint floor_div(longint n, longint d);
        longint q, r;
        q = n / d;
        r = n - q * d;
        if (r != 0 && ((r < 0) != (d < 0)))
            q = q - 1;
        return q;
    endfunction

    // floor(a * b / d), whole quotient clamped at 2^40
    function automatic longint scaled_floor(longint a, longint b, longint d);
        longint q, rem;
        q = floor_div(a, d);
        rem = a - q * d;
        if (q > (64'sd1 <<< 40))
            q = 64'sd1 <<< 40;
        if (q < -(64'sd1 <<< 40))
            q = -(64'sd1 <<< 40);
        return q * b + floor_div(rem * b, d);
    endfunction

    function automatic longint clamp_to(longint v, longint lo, longint hi, ref bit sat);
        if (v > hi) begin
            sat = 1'b1;
            return hi;
        end
        if (v < lo) begin
            sat = 1'b1;
            return lo;
        end
        return v;
    endfunction

    function automatic out_t project_point(in_t pt);
        longint p [3];
        longint clip [4];
        longint w, sx, sy, sd;
        bit     sat;
        out_t   o;
        p[0] = longint'(pt.world_x);
        p[1] = longint'(pt.world_y);
        p[2] = longint'(pt.world_z);
        for (int i = 0; i < 4; i++) begin
            clip[i] = longint'($signed(mat[i][63:48])) * (64'sd1 <<< COORD_FRAC_BITS);
            for (int j = 0; j < 3; j++)
                clip[i] += longint'($signed(mat[i][16*j +: 16])) * p[j];
        end
        w = clip[3];
        o = '0;
        sat = 1'b0;
        if (w == 0) begin
            o.w_zero = 1'b1;
            return o;
        end
        sx = floor_div(scaled_floor(clip[0] + w, longint'(vp_width), w), 2)
             + longint'(vp_left);
        sy = floor_div(scaled_floor(clip[1] + w, longint'(vp_height), w), 2)
             + longint'(vp_top);
        sd = scaled_floor(clip[2] + w, 64'sd32768, w);
        sx = clamp_to(sx, -8388608, 8388607, sat);
        sy = clamp_to(sy, -8388608, 8388607, sat);
        sd = clamp_to(sd, 0, 65535, sat);
        o.screen_x     = sx[23:0];
        o.screen_y     = sy[23:0];
        o.screen_depth = sd[15:0];
        o.saturated    = sat;
        return o;
    endfunction

    function automatic void reset_registers();
        mat[0] = ROW0_RESET;
        mat[1] = ROW1_RESET;
        mat[2] = ROW2_RESET;
        mat[3] = ROW3_RESET;
        vp_left = 16'sd0;
        vp_top = 16'sd1;
        vp_width = 16'sd1;
        vp_height = -16'sd1;
    endfunction

    function automatic in_t point(int x, int y, int z);
        in_t pt;
        pt.world_x = x;
        pt.world_y = y;
        pt.world_z = z;
        return pt;
    endfunction

    function automatic out_t screen(int x, int y, int d, bit wz, bit sat);
        out_t o;
        o.screen_x = x[23:0];
        o.screen_y = y[23:0];
        o.screen_depth = d[15:0];
        o.w_zero = wz;
        o.saturated = sat;
        return o;
    endfunction

    task automatic add_point(in_t pt, bit known, out_t res);
        step_t s;
        s = '{default: '0};
        s.pt = pt;
        s.known = known;
        s.res = res;
        table_q.push_back(s);
    endtask

    task automatic add_write(logic [3:0] idx, logic [63:0] d);
        step_t s;
        s = '{default: '0};
        s.is_write = 1'b1;
        s.idx = idx;
        s.wdata = d;
        table_q.push_back(s);
    endtask

    // write one register once the pipeline has drained
    task automatic write_reg(logic [3:0] idx, logic [63:0] d);
        while (pending_q.size() != 0)
            @(negedge aclk);
        repeat (LATENCY) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_ROW0, REG_ROW1, REG_ROW2, REG_ROW3: mat[idx[1:0]] = d;
            REG_VP_LEFT:   vp_left = d[15:0];
            REG_VP_TOP:    vp_top = d[15:0];
            REG_VP_WIDTH:  vp_width = d[15:0];
            REG_VP_HEIGHT: vp_height = d[15:0];
            default: ;
        endcase
        n_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // offer one point; called at a falling edge, returns at one
    task automatic send_point(in_t pt, bit known, out_t res);
        while (idle_on && $urandom_range(99) < 22) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= pt;
        do @(posedge aclk); while (!s_ready);
        pending_q.push_back(known ? res : project_point(pt));
        n_items++;
        @(negedge aclk);
    endtask

    function automatic logic [15:0] rand_entry();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom);
            3: return 16'h0000;
            default: return 16'(int'($urandom_range(1024)) - 512);
        endcase
    endfunction

    function automatic logic [15:0] rand_view();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom);
            default: return 16'(int'($urandom_range(4000)) - 2000);
        endcase
    endfunction

    function automatic int rand_coord();
        case ($urandom_range(5))
            0: return int'($urandom);
            1: return int'($urandom_range(16777216)) - 8388608;
            2: begin
                case ($urandom_range(3))
                    0: return 32'h7FFFFFFF;
                    1: return 32'h80000000;
                    2: return 0;
                    default: return -1;
                endcase
            end
            default: return int'($urandom_range(524288)) - 262144;
        endcase
    endfunction

    always @(negedge aclk) begin
        if (hold_active)
            m_ready <= 1'b0;
        else
            m_ready <= !(idle_on && $urandom_range(99) < 22);
    end

    // long hold-off of the result side, counted here in cycles
    initial begin
        hold_active = 1'b0;
        wait (long_hold_req);
        @(negedge aclk);
        hold_active = 1'b1;
        repeat (LONG_HOLD) @(posedge aclk);
        @(negedge aclk);
        hold_active = 1'b0;
    end

    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", m_data);
            end else begin
                want = pending_q.pop_front();
                if (m_data.screen_x !== want.screen_x || m_data.screen_y !== want.screen_y
                    || m_data.screen_depth !== want.screen_depth
                    || m_data.w_zero !== want.w_zero
                    || m_data.saturated !== want.saturated) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, m_data);
                end
                if (want.w_zero)
                    n_wzero++;
                if (want.saturated)
                    n_sat++;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int n;
        int row3_mode;
        out_t none;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_NONE;
        cfg_data = '0;
        idle_on = 1'b1;
        long_hold_req = 1'b0;
        mismatches = 0;
        n_items = 0;
        n_results = 0;
        n_wzero = 0;
        n_sat = 0;
        n_writes = 0;
        cycles = 0;
        none = '0;
        reset_registers();

        // reset registers: identity matrix, unit viewport flipped vertically
        add_point(point(0, 0, 0), 1'b1, screen(0, 0, 32768, 1'b0, 1'b0));
        add_point(point(0, 0, 65536), 1'b1, screen(0, 0, 65535, 1'b0, 1'b1));
        add_point(point(0, 0, -65536), 1'b1, screen(0, 0, 0, 1'b0, 1'b0));
        add_point(point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF), 1'b0, none);
        add_point(point(32'h80000000, 32'h80000000, 32'h80000000), 1'b0, none);
        add_point(point(32'h7FFFFFFF, 32'h80000000, -1), 1'b0, none);
        add_point(point(-1, -1, -1), 1'b0, none);
        add_write(REG_VP_LEFT, 64'hFFFF_FFFF_FFFF_8000);
        add_write(REG_VP_TOP, 64'h7FFF);
        add_write(REG_VP_WIDTH, 64'h7FFF);
        add_write(REG_VP_HEIGHT, 64'h8000);
        add_point(point(65536, -65536, 0), 1'b0, none);
        add_point(point(32'h7FFFFFFF, 32'h80000000, 32'h80000000), 1'b0, none);
        add_write(REG_ROW0, 64'h8000_7FFF_8000_7FFF);
        add_write(REG_ROW1, 64'h7FFF_8000_7FFF_8000);
        add_write(REG_ROW2, 64'hFFFF_0001_FF00_0100);
        add_point(point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF), 1'b0, none);
        add_point(point(12345, -67890, 4096), 1'b0, none);
        // zero homogeneous w
        add_write(REG_ROW3, 64'h0);
        add_point(point(32'h7FFFFFFF, 0, 32'h80000000), 1'b1, screen(0, 0, 0, 1'b1, 1'b0));
        add_point(point(0, 0, 0), 1'b1, screen(0, 0, 0, 1'b1, 1'b0));
        // w = x - 65536, negative and small for the last point, so quotients blow up
        add_write(REG_ROW3, 64'hFFFF_0000_0000_0001);
        add_point(point(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF), 1'b0, none);
        add_write(REG_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
        add_point(point(-65536, 65536, 131072), 1'b0, none);

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (table_q[k]) begin
            if (table_q[k].is_write) begin
                // drop the last point's beat before touching the registers
                s_valid <= 1'b0;
                write_reg(table_q[k].idx, table_q[k].wdata);
            end else begin
                send_point(table_q[k].pt, table_q[k].known, table_q[k].res);
            end
        end
        s_valid <= 1'b0;

        for (int ph = 0; ph < PHASES; ph++) begin
            for (int r = 0; r < 3; r++)
                write_reg(reg_idx_t'(r), {rand_entry(), rand_entry(), rand_entry(),
                                          rand_entry()});
            row3_mode = (ph == 2) ? 0 : $urandom_range(1, 3);
            case (row3_mode)
                0: write_reg(REG_ROW3, 64'h0);
                1: write_reg(REG_ROW3, {16'($urandom_range(1, 1024)), 48'h0});
                default: write_reg(REG_ROW3, {rand_entry(), rand_entry(), rand_entry(),
                                              rand_entry()});
            endcase
            write_reg(REG_VP_LEFT, 64'(rand_view()));
            write_reg(REG_VP_TOP, 64'(rand_view()));
            write_reg(REG_VP_WIDTH, 64'(rand_view()));
            write_reg(REG_VP_HEIGHT, 64'(rand_view()));
            if (ph == 3)
                write_reg(REG_NONE, 64'($urandom));
            idle_on = (ph != 1);
            if (ph == 4)
                long_hold_req = 1'b1;
            n = (ph == 2) ? 40 : 135;
            for (int k = 0; k < n; k++)
                send_point(point(rand_coord(), rand_coord(), rand_coord()), 1'b0, none);
            s_valid <= 1'b0;
            idle_on = 1'b1;
        end

        while (pending_q.size() != 0)
            @(negedge aclk);
        repeat (LATENCY) @(negedge aclk);

        $display("%0d points sent, %0d results, %0d with zero w, %0d saturated",
                 n_items, n_results, n_wzero, n_sat);
        $display("%0d register writes over %0d settings, %0d mismatches",
                 n_writes, PHASES + 1, mismatches);
        if (mismatches == 0 && pending_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> files.f
rtl/wtsp_pkg.sv
rtl/world_to_screen_projection.sv
tb/world_to_screen_projection_test.sv
